/* rtl/mbps_pkg.sv */
`timescale 1ns / 1ps

package mbps_pkg;

  // window depth, also the longest pattern
  localparam int MaxPattern = 16;
  localparam int ByteW      = 8;
  localparam int LenW       = $clog2(MaxPattern + 1);
  localparam int IdxW       = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int AddrW      = 32;
  localparam int CfgDataW   = 64;
  localparam int CfgIdxW    = 3;
  localparam int PatW       = MaxPattern * ByteW;

  localparam logic [ByteW-1:0] WildByte = 8'hFF;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRegionBase = 3'd0,
    CfgPatLow     = 3'd1,
    CfgPatHigh    = 3'd2,
    CfgCareMask   = 3'd3,
    CfgPatLen     = 3'd4,
    CfgWildMode   = 3'd5
  } cfg_idx_e;

  typedef logic [MaxPattern-1:0][ByteW-1:0] window_t;

  // item held in the compare stage together with the window it sees
  typedef struct packed {
    window_t          bytes;
    logic [LenW-1:0]  fill;
    logic [AddrW-1:0] cur;
    logic             last;
  } stage_t;

  // pattern settings used by the compare
  typedef struct packed {
    logic [PatW-1:0]       pattern;
    logic [MaxPattern-1:0] care;
    logic [LenW-1:0]       len;
    logic                  wild;
  } match_cfg_t;

  typedef struct packed {
    logic             hit;
    logic [AddrW-1:0] start;
  } match_res_t;

endpackage

/* rtl/mbps_if.sv */
`timescale 1ns / 1ps

interface mbps_in_if import mbps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             end_of_region;

  modport source (output valid, output data_byte, output end_of_region, input ready);
  modport sink (input valid, input data_byte, input end_of_region, output ready);
endinterface

interface mbps_out_if import mbps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [AddrW-1:0] match_address;

  modport source (output valid, output found, output match_address, input ready);
  modport sink (input valid, input found, input match_address, output ready);
endinterface

/* rtl/mbps_window.sv */
`timescale 1ns / 1ps

module mbps_window import mbps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             end_of_region_i,
  output stage_t           stage_o
);

  window_t          bytes_q, bytes_d, bytes_base;
  logic [LenW-1:0]  fill_q, fill_d, fill_base;
  logic [AddrW-1:0] offset_q, offset_d;
  logic [AddrW-1:0] cur_q, cur_d;
  logic             last_q;
  logic             clear_q;

  // a finished region restarts from an empty window
  always_comb begin
    bytes_base = clear_q ? '0 : bytes_q;
    fill_base  = clear_q ? '0 : fill_q;
    cur_d      = clear_q ? '0 : offset_q;
    offset_d   = cur_d + AddrW'(1);
    bytes_d    = {bytes_base[MaxPattern-2:0], data_byte_i};
    fill_d     = (fill_base < LenW'(MaxPattern)) ? fill_base + LenW'(1) : fill_base;
  end

  // window bytes are payload, gated by the fill count
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      bytes_q <= bytes_d;
      cur_q   <= cur_d;
      last_q  <= end_of_region_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      offset_q <= '0;
      clear_q  <= 1'b0;
    end else if (accept_i) begin
      fill_q   <= fill_d;
      offset_q <= offset_d;
      clear_q  <= end_of_region_i;
    end
  end

  assign stage_o = '{bytes: bytes_q, fill: fill_q, cur: cur_q, last: last_q};

endmodule

/* rtl/mbps_compare.sv */
`timescale 1ns / 1ps

module mbps_compare import mbps_pkg::*; (
  input  stage_t     stage_i,
  input  match_cfg_t cfg_i,
  output match_res_t res_o
);

  logic [LenW-1:0]       eff_len;
  logic [MaxPattern-1:0] lane_ok;

  // clamp the configured length into 1..MaxPattern
  always_comb begin
    if (cfg_i.len == '0) begin
      eff_len = LenW'(1);
    end else if (cfg_i.len > LenW'(MaxPattern)) begin
      eff_len = LenW'(MaxPattern);
    end else begin
      eff_len = cfg_i.len;
    end
  end

  // lane k holds the byte received k words ago, lined up with pattern byte len-1-k
  for (genvar k = 0; k < MaxPattern; k++) begin : g_lane
    logic [LenW-1:0]  pos;
    logic [IdxW-1:0]  pidx;
    logic [ByteW-1:0] pbyte;
    logic             care;

    always_comb begin
      pos   = eff_len - LenW'(1) - LenW'(k);
      pidx  = pos[IdxW-1:0];
      pbyte = cfg_i.pattern[ByteW*pidx +: ByteW];
      care  = cfg_i.wild ? (pbyte != WildByte) : cfg_i.care[pidx];
      lane_ok[k] = (LenW'(k) >= eff_len) || !care || (stage_i.bytes[k] == pbyte);
    end
  end

  assign res_o.hit   = (stage_i.fill >= eff_len) && (&lane_ok);
  assign res_o.start = stage_i.cur - AddrW'(eff_len - LenW'(1));

endmodule

/* rtl/masked_byte_pattern_search_core.sv */
`timescale 1ns / 1ps

// Masked byte pattern search core
//
// in_i carries one byte of a memory region per word, with end_of_region on
// the last byte. A window of the newest 16 bytes is compared in parallel with
// the configured pattern (care mask in mode 0, 0xFF wildcards in mode 1).
// out_o gives at most one word per region: found=1 with region_base plus the
// match start offset on the first match, or found=0 with address 0 when the
// region ends without one. A match lies wholly within the region.
// One byte is accepted every cycle while the input is not stalled. The byte
// that causes a result is registered in the window, compared by the single
// compare stage, and the result is then registered in the result register.
// When out_o is stalled the result register holds and the compare stage
// keeps its byte only if it produces a result, so input stalls once a second
// result-bearing byte reaches the compare stage. Reset clears the scan state
// and loads the register defaults (care mask all ones, length 16, mode 0).
// Registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user
// must write them only while the block is idle, which the block does not enforce.
module masked_byte_pattern_search_core import mbps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  mbps_in_if.sink             in_i,
  mbps_out_if.source          out_o
);

  logic [AddrW-1:0]      region_base_q;
  logic [CfgDataW-1:0]   pat_low_q, pat_high_q;
  logic [MaxPattern-1:0] care_mask_q;
  logic [LenW-1:0]       pat_len_q;
  logic                  wild_mode_q;

  logic             stage_vld_q;
  logic             found_state_q;
  logic             out_vld_q;
  logic             out_found_q;
  logic [AddrW-1:0] out_addr_q;

  stage_t     stage;
  match_cfg_t mcfg;
  match_res_t mres;
  logic       accept, advance, emit, out_free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_base_q <= '0;
      pat_low_q     <= '0;
      pat_high_q    <= '0;
      care_mask_q   <= '1;
      pat_len_q     <= LenW'(MaxPattern);
      wild_mode_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgRegionBase: region_base_q <= cfg_wdata_i[AddrW-1:0];
        CfgPatLow:     pat_low_q     <= cfg_wdata_i;
        CfgPatHigh:    pat_high_q    <= cfg_wdata_i;
        CfgCareMask:   care_mask_q   <= cfg_wdata_i[MaxPattern-1:0];
        CfgPatLen:     pat_len_q     <= cfg_wdata_i[LenW-1:0];
        CfgWildMode:   wild_mode_q   <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  assign mcfg = '{
    pattern: PatW'({pat_high_q, pat_low_q}),
    care:    care_mask_q,
    len:     pat_len_q,
    wild:    wild_mode_q
  };

  // handshake: the compare stage moves on unless its result cannot be stored
  assign emit     = stage_vld_q && !found_state_q && (mres.hit || stage.last);
  assign out_free = !out_vld_q || out_o.ready;
  assign advance  = stage_vld_q && (!emit || out_free);
  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = !stage_vld_q || advance;

  mbps_window u_window (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (in_i.data_byte),
    .end_of_region_i (in_i.end_of_region),
    .stage_o         (stage)
  );

  mbps_compare u_compare (
    .stage_i (stage),
    .cfg_i   (mcfg),
    .res_o   (mres)
  );

  // compare stage valid and per-region found flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q   <= 1'b0;
      found_state_q <= 1'b0;
    end else begin
      if (accept) begin
        stage_vld_q <= 1'b1;
      end else if (advance) begin
        stage_vld_q <= 1'b0;
      end
      if (advance) begin
        found_state_q <= stage.last ? 1'b0 : (found_state_q || mres.hit);
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && emit) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_found_q <= mres.hit;
      out_addr_q  <= mres.hit ? region_base_q + mres.start : '0;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.found         = out_found_q;
  assign out_o.match_address = out_addr_q;

  // a miss report always carries address zero
  a_miss_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_found_q |-> out_addr_q == '0)
    else $error("miss result with nonzero address");

  // a match inside a region marks the region as found
  a_found_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && mres.hit && !stage.last |=> found_state_q)
    else $error("match did not set found flag");

  // input stalls only while the compare stage holds a word
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> stage_vld_q && emit && !out_free)
    else $error("input stalled without a blocked result");

  // the fill count saturates at the window depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage.fill <= LenW'(MaxPattern))
    else $error("window fill out of range");

endmodule

/* test/tb_masked_byte_pattern_search_core.sv */
`timescale 1ns / 1ps

module tb_masked_byte_pattern_search_core;
  import mbps_pkg::*;

  localparam int SettleCycles = 4;
  localparam int IdleLimit    = 3000;
  localparam int LongHold     = 400;
  localparam int ByteTarget   = 1550;
  localparam int MaxReports   = 50;

  // indexes past the end of the register list, writes there are dropped
  localparam logic [CfgIdxW-1:0] CfgSpareA = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 3'd7;

  typedef enum int {RxAlways, RxCoin, RxSparse, RxMostly} rx_mode_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } scan_item_t;

  typedef struct packed {
    logic             found;
    logic [AddrW-1:0] addr;
  } scan_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  mbps_in_if  in_if ();
  mbps_out_if out_if ();

  masked_byte_pattern_search_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  scan_item_t   byte_queue[$];
  scan_result_t predicted_results[$];

  int error_count    = 0;
  int bytes_accepted = 0;
  int results_seen   = 0;
  int bytes_queued   = 0;
  int idle_cycles    = 0;
  bit steady_tx      = 1'b0;

  // register copies
  logic [AddrW-1:0]      base_reg;
  logic [63:0]           pat_lo_reg;
  logic [63:0]           pat_hi_reg;
  logic [MaxPattern-1:0] care_reg;
  logic [4:0]            len_reg;
  logic                  wild_reg;

  // scan state copies
  window_t          win;
  int               win_fill;
  logic [AddrW-1:0] scan_offset;
  bit               scan_found;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int eff_len();
    int l;
    l = len_reg;
    if (l == 0) l = 1;
    if (l > MaxPattern) l = MaxPattern;
    return l;
  endfunction

  function automatic logic [ByteW-1:0] pat_at(input int i);
    logic [PatW-1:0] p;
    p = {pat_hi_reg, pat_lo_reg};
    return p[i*ByteW +: ByteW];
  endfunction

  function automatic bit byte_cares(input int i);
    if (wild_reg) return pat_at(i) != WildByte;
    return care_reg[i];
  endfunction

  task automatic clear_scan();
    win         = '0;
    win_fill    = 0;
    scan_offset = '0;
    scan_found  = 1'b0;
  endtask

  task automatic set_register(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    case (idx)
      CfgRegionBase: base_reg = value[AddrW-1:0];
      CfgPatLow:     pat_lo_reg = value;
      CfgPatHigh:    pat_hi_reg = value;
      CfgCareMask:   care_reg = value[MaxPattern-1:0];
      CfgPatLen:     len_reg = value[4:0];
      CfgWildMode:   wild_reg = value[0];
      default: ;
    endcase
  endtask

  // shift one byte into the window and work out the result it causes
  task automatic scan_byte(input scan_item_t it);
    int               len;
    logic [AddrW-1:0] cur;
    bit               hit;
    len = eff_len();
    cur = scan_offset;
    win = {win[MaxPattern-2:0], it.data};
    if (win_fill < MaxPattern) win_fill++;
    scan_offset = cur + 1;
    hit = 1'b1;
    for (int i = 0; i < len; i++) begin
      if (byte_cares(i) && win[len-1-i] != pat_at(i)) hit = 1'b0;
    end
    if (!scan_found && win_fill >= len && hit) begin
      scan_found = 1'b1;
      predicted_results.push_back({1'b1, base_reg + cur - AddrW'(len - 1)});
    end else if (it.last && !scan_found) begin
      predicted_results.push_back({1'b0, {AddrW{1'b0}}});
    end
    if (it.last) clear_scan();
  endtask

  task automatic report_mismatch(input string what, input logic [AddrW-1:0] got,
                                 input logic [AddrW-1:0] want);
    error_count++;
    if (error_count <= MaxReports)
      $display("%0t: result %0d, %s: got %h, want %h", $time, results_seen, what, got, want);
  endtask

  task automatic check_result();
    scan_result_t want;
    results_seen++;
    if (predicted_results.size() == 0) begin
      report_mismatch("word with none awaited", out_if.match_address, '0);
    end else begin
      want = predicted_results.pop_front();
      if (out_if.found !== want.found)
        report_mismatch("found", AddrW'(out_if.found), AddrW'(want.found));
      if (out_if.match_address !== want.addr)
        report_mismatch("match_address", out_if.match_address, want.addr);
    end
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    set_register(idx, value);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic push_byte(input logic [ByteW-1:0] data, input logic last);
    byte_queue.push_back({data, last});
    bytes_queued++;
  endtask

  // wait until every byte is taken and every result is in
  task automatic drain();
    while (byte_queue.size() != 0 || predicted_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // new random settings, extremes included, junk in the unused upper bits
  task automatic pick_settings();
    logic [127:0]          pat;
    logic [MaxPattern-1:0] care;
    logic [4:0]            len;
    logic [AddrW-1:0]      base;
    logic                  wild;
    int                    r;
    wild = $urandom_range(0, 1);
    pat  = {$urandom, $urandom, $urandom, $urandom};
    if (wild) begin
      for (int i = 0; i < MaxPattern; i++)
        if ($urandom_range(0, 3) == 0) pat[i*ByteW +: ByteW] = WildByte;
    end
    r = $urandom_range(0, 9);
    care = (r == 0) ? '0 : (r == 1) ? '1 : MaxPattern'($urandom);
    r = $urandom_range(0, 19);
    case (r)
      0:       len = 5'd0;
      1:       len = 5'($urandom_range(17, 31));
      2:       len = 5'd1;
      3:       len = 5'd16;
      default: len = 5'($urandom_range(1, 16));
    endcase
    r = $urandom_range(0, 7);
    base = (r == 0) ? '0 : (r == 1) ? '1 : (r == 2) ? 32'hFFFF_FFF8 : $urandom;
    cfg_write(CfgRegionBase, {$urandom, base});
    cfg_write(CfgPatLow, pat[63:0]);
    cfg_write(CfgPatHigh, pat[127:64]);
    cfg_write(CfgCareMask, {$urandom, 16'($urandom), care});
    cfg_write(CfgPatLen, {$urandom, 27'($urandom), len});
    cfg_write(CfgWildMode, {$urandom, 31'($urandom), wild});
    if ($urandom_range(0, 3) == 0)
      cfg_write(($urandom_range(0, 1) != 0) ? CfgSpareA : CfgSpareB, {$urandom, $urandom});
  endtask

  // one region: mostly a planted pattern in random content, some cut off
  // by the region end, some with a broken byte, some plain noise
  task automatic add_region();
    logic [ByteW-1:0] region[$];
    int               rlen, plen, pos, kind, r, lo, j;
    bit               narrow;
    r = $urandom_range(0, 99);
    rlen = (r < 75) ? $urandom_range(1, 24) : (r < 95) ? $urandom_range(25, 64)
         : $urandom_range(65, 200);
    plen   = eff_len();
    narrow = ($urandom_range(0, 2) == 0);
    for (int i = 0; i < rlen; i++) begin
      if (narrow && $urandom_range(0, 1) != 0)
        region.push_back(pat_at($urandom_range(0, plen - 1)));
      else
        region.push_back(8'($urandom));
    end
    kind = $urandom_range(0, 99);
    pos  = -1;
    if (kind < 60 && rlen >= plen) begin
      pos = $urandom_range(0, rlen - plen);
    end else if (kind < 75 && plen > 1) begin
      lo  = (rlen >= plen) ? rlen - plen + 1 : 0;
      pos = $urandom_range(lo, rlen - 1);
    end else if (kind < 85 && rlen >= plen) begin
      pos = $urandom_range(0, rlen - plen);
    end
    if (pos >= 0) begin
      for (int i = 0; i < plen && pos + i < rlen; i++)
        region[pos+i] = byte_cares(i) ? pat_at(i) : 8'($urandom);
      // break one compared byte
      if (kind >= 75 && kind < 85) begin
        j = $urandom_range(0, plen - 1);
        if (byte_cares(j)) region[pos+j] = region[pos+j] ^ 8'($urandom_range(1, 255));
      end
    end
    for (int i = 0; i < rlen; i++) push_byte(region[i], i == rlen - 1);
  endtask

  // input driver, bursts with random gaps unless steady_tx is set
  int burst_left = 0;
  int gap_left   = 0;
  bit offering;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid         <= 1'b0;
      in_if.data_byte     <= '0;
      in_if.end_of_region <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      offering = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        scan_byte(byte_queue.pop_front());
        bytes_accepted++;
        offering = 1'b0;
      end
      if (!offering && byte_queue.size() > 0) begin
        if (gap_left > 0 && !steady_tx) begin
          gap_left--;
        end else begin
          offering = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
          end
        end
      end
      in_if.valid <= offering;
      if (offering) begin
        in_if.data_byte     <= byte_queue[0].data;
        in_if.end_of_region <= byte_queue[0].last;
      end
    end
  end

  // result monitor and receiver stall pattern
  int       hold_left      = 0;
  int       rx_cycle       = 0;
  bit       long_hold_done = 1'b0;
  bit       take;
  rx_mode_e rx_mode        = RxAlways;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) check_result();
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
      // one long hold-off while the sender still has plenty queued
      if (hold_left == 0 && !long_hold_done && bytes_accepted >= 600 && byte_queue.size() > 20) begin
        hold_left      = LongHold;
        long_hold_done = 1'b1;
      end else if (hold_left == 0 && $urandom_range(0, 699) == 0) begin
        hold_left = $urandom_range(10, 60);
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else begin
        case (rx_mode)
          RxAlways: take = 1'b1;
          RxCoin:   take = $urandom_range(0, 1);
          RxSparse: take = (rx_cycle % 4 == 0);
          default:  take = ($urandom_range(0, 9) != 0);
        endcase
      end
      out_if.ready <= take;
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  initial begin
    base_reg   = '0;
    pat_lo_reg = '0;
    pat_hi_reg = '0;
    care_reg   = '1;
    len_reg    = 5'd16;
    wild_reg   = 1'b0;
    clear_scan();
    rst_ni    <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: sixteen zero bytes match all-zero pattern on the last byte
    for (int i = 0; i < 16; i++) push_byte(8'h00, i == 15);
    drain();

    // length zero acts as one, base plus offset wraps, spare indexes ignored
    cfg_write(CfgRegionBase, 64'h0000_0000_FFFF_FFFF);
    cfg_write(CfgPatLen, '0);
    cfg_write(CfgPatLow, 64'h0000_0000_0000_00A5);
    cfg_write(CfgSpareA, '1);
    cfg_write(CfgSpareB, '1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hA5, 1'b1);
    drain();

    // length above the window, all wildcards, region shorter than pattern
    cfg_write(CfgPatLen, 64'd31);
    cfg_write(CfgWildMode, 64'd1);
    cfg_write(CfgPatLow, '1);
    cfg_write(CfgPatHigh, '1);
    push_byte(8'hFF, 1'b1);
    drain();

    // two-byte pattern with a wildcard, second hit in the region stays silent
    cfg_write(CfgPatLen, 64'd2);
    cfg_write(CfgPatLow, 64'h0000_0000_0000_FF12);
    cfg_write(CfgRegionBase, 64'h0000_0000_1234_5678);
    cfg_write(CfgCareMask, '0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'hFF, 1'b1);
    drain();

    // random phases, new settings between them
    while (bytes_queued < ByteTarget) begin
      pick_settings();
      steady_tx = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(3, 12)) add_region();
      drain();
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
